// File: hdl/ctt_pkg.sv
// Shared types and constants of the client topic table.
package ctt_pkg;

    localparam int MODE_W      = 3;
    localparam int TOPIC_W     = 16;
    localparam int FLAGS_W     = 8;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int REQ_BITS    = MODE_W + TOPIC_W + FLAGS_W;
    localparam logic [TOPIC_W-1:0] RESET_MARKER = 16'hFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_SUB   = 3'd0,
        MODE_ADD_PUB   = 3'd1,
        MODE_DEL_SUB   = 3'd2,
        MODE_QUERY_SUB = 3'd3,
        MODE_CLEAR_ALL = 3'd4
    } mode_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request and match vectors
        logic commit;    // apply table update and load result
    } ctt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;  // result register full and not taken this cycle
    } ctt_sts_t;

endpackage

// File: hdl/ctt_ctrl.sv
// Request sequencer of the client topic table.
module ctt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ctt_pkg::ctt_sts_t sts,
    output ctt_pkg::ctt_cmd_t cmd
);
    import ctt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!sts.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_UPDATE: begin
                cmd.commit = !sts.out_busy;
            end
            default: ;
        endcase
    end

endmodule

// File: hdl/ctt_datapath.sv
// Topic tables, parallel id compare, update logic and result register.
module ctt_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ctt_pkg::REQ_BITS-1:0]   req,
    input  logic                           cfg_we,
    input  logic [ctt_pkg::TOPIC_W-1:0]    cfg_data,
    input  ctt_pkg::ctt_cmd_t              cmd,
    output ctt_pkg::ctt_sts_t              sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic                           res_accepted,
    output logic                           res_present
);
    import ctt_pkg::*;

    logic [TOPIC_W-1:0] free_marker_reg;

    logic [TOPIC_W-1:0] sub_ids_reg   [ENTRIES];
    logic [TOPIC_W-1:0] sub_ids_next  [ENTRIES];
    logic [FLAGS_W-1:0] sub_flags_reg [ENTRIES];
    logic [FLAGS_W-1:0] sub_flags_next[ENTRIES];
    logic [TOPIC_W-1:0] pub_ids_reg   [ENTRIES];
    logic [TOPIC_W-1:0] pub_ids_next  [ENTRIES];

    logic [MODE_W-1:0]  mode_reg;
    logic [TOPIC_W-1:0] tid_reg;
    logic [FLAGS_W-1:0] flags_reg;

    logic [ENTRIES-1:0] sub_hit_reg, sub_free_reg, pub_hit_reg, pub_free_reg;
    logic [ENTRIES-1:0] sub_hit_cmp, sub_free_cmp, pub_hit_cmp, pub_free_cmp;
    logic [ENTRIES-1:0] sub_hit_oh, sub_free_oh, pub_free_oh;

    logic m_tvalid_reg, m_tvalid_next;
    logic acc_reg, acc_next;
    logic pres_reg, pres_next;

    logic [TOPIC_W-1:0] req_tid;
    assign req_tid = req[MODE_W +: TOPIC_W];

    // compare every entry against the incoming id and the free marker
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            sub_hit_cmp[i]  = (sub_ids_reg[i] == req_tid);
            sub_free_cmp[i] = (sub_ids_reg[i] == free_marker_reg);
            pub_hit_cmp[i]  = (pub_ids_reg[i] == req_tid);
            pub_free_cmp[i] = (pub_ids_reg[i] == free_marker_reg);
        end
    end

    // lowest set bit of each vector
    assign sub_hit_oh  = sub_hit_reg  & (~sub_hit_reg  + ENTRIES'(1));
    assign sub_free_oh = sub_free_reg & (~sub_free_reg + ENTRIES'(1));
    assign pub_free_oh = pub_free_reg & (~pub_free_reg + ENTRIES'(1));

    always_comb begin
        sub_ids_next   = sub_ids_reg;
        sub_flags_next = sub_flags_reg;
        pub_ids_next   = pub_ids_reg;
        acc_next       = acc_reg;
        pres_next      = pres_reg;
        if (cmd.commit) begin
            acc_next  = 1'b0;
            pres_next = 1'b0;
            case (mode_t'(mode_reg))
                MODE_ADD_SUB: begin
                    pres_next = |sub_hit_reg;
                    acc_next  = (|sub_hit_reg) || (|sub_free_reg);
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (|sub_hit_reg) begin
                            if (sub_hit_oh[i]) begin
                                sub_flags_next[i] = flags_reg;
                            end
                        end else if (sub_free_oh[i]) begin
                            sub_ids_next[i]   = tid_reg;
                            sub_flags_next[i] = flags_reg;
                        end
                    end
                end
                MODE_ADD_PUB: begin
                    pres_next = |pub_hit_reg;
                    acc_next  = (|pub_hit_reg) || (|pub_free_reg);
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!(|pub_hit_reg) && pub_free_oh[i]) begin
                            pub_ids_next[i] = tid_reg;
                        end
                    end
                end
                MODE_DEL_SUB: begin
                    pres_next = |sub_hit_reg;
                    acc_next  = 1'b1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (sub_hit_oh[i]) begin
                            sub_ids_next[i]   = free_marker_reg;
                            sub_flags_next[i] = '0;
                        end
                    end
                end
                MODE_QUERY_SUB: begin
                    pres_next = |sub_hit_reg;
                    acc_next  = 1'b1;
                end
                MODE_CLEAR_ALL: begin
                    acc_next = 1'b1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        sub_ids_next[i] = free_marker_reg;
                        pub_ids_next[i] = free_marker_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_marker_reg <= RESET_MARKER;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                sub_ids_reg[i]   <= RESET_MARKER;
                sub_flags_reg[i] <= '0;
                pub_ids_reg[i]   <= RESET_MARKER;
            end
        end else begin
            if (cfg_we) begin
                free_marker_reg <= cfg_data;
            end
            m_tvalid_reg  <= m_tvalid_next;
            sub_ids_reg   <= sub_ids_next;
            sub_flags_reg <= sub_flags_next;
            pub_ids_reg   <= pub_ids_next;
        end
    end

    // request, match vectors and result bits, payload only
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg     <= req[MODE_W-1:0];
            tid_reg      <= req_tid;
            flags_reg    <= req[MODE_W+TOPIC_W +: FLAGS_W];
            sub_hit_reg  <= sub_hit_cmp;
            sub_free_reg <= sub_free_cmp;
            pub_hit_reg  <= pub_hit_cmp;
            pub_free_reg <= pub_free_cmp;
        end
        acc_reg  <= acc_next;
        pres_reg <= pres_next;
    end

    assign sts.out_busy  = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign res_accepted  = acc_reg;
    assign res_present   = pres_reg;

endmodule

// File: hdl/client_topic_table_unit.sv
// Top level of the client topic table: controller, datapath and ports.
//
// Keeps one client's subscribe table (topic id + flag byte) and publish table
// (topic id), ENTRIES deep each, in flip-flops. An entry is free when its id
// equals the free_marker register (reset 0xFFFF). Each request item is checked
// against every entry of both tables in parallel in the cycle it is accepted;
// the update state then picks the lowest match or lowest free entry, updates
// the table and loads the result register. When the result is taken at once,
// an item passes the accept cycle (compare) and then the update cycle.
// A result that is not taken holds the next item in its update cycle until
// the result register frees up; a new item is accepted while a result waits.
// Modes: add subscribe, add publish, delete subscribe, query subscribe,
// clear all; codes 5 to 7 change nothing and give accepted 0, was_present 0.
// Write free_marker only while no item is in flight.
module client_topic_table_unit #(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [2:0] mode, [18:3] topic, [26:19] sub_flags
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] accepted, [1] was_present
    // free marker register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import ctt_pkg::*;

    ctt_cmd_t cmd;
    ctt_sts_t sts;
    logic     res_accepted;
    logic     res_present;

    ctt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ctt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (s_tdata[REQ_BITS-1:0]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .res_accepted (res_accepted),
        .res_present  (res_present)
    );

    // register write always taken
    assign cfg_ready = 1'b1;
    assign m_tdata   = {6'b0, res_present, res_accepted};

endmodule

// File: hdl/ctt_checker.sv
// Port-level checks of the client topic table and their binding.
module ctt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [15:0] cfg_data
);

    // held result stays valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // held result stays unchanged
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // one item at a time: busy in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request item taken while previous one in update");

    // a refused add never reports a present id
    a_refused_not_present: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> !m_tdata[1])
        else $error("refused item reports id present");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'b0))
        else $error("result padding not zero");

endmodule

bind client_topic_table_unit ctt_checker u_ctt_checker (.*);
